// ===== src/porter_duff_pixel_blend_defines.svh =====
// Assertion macros for the Porter-Duff pixel blender checker.
`ifndef PORTER_DUFF_PIXEL_BLEND_DEFINES_SVH
`define PORTER_DUFF_PIXEL_BLEND_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PDB_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PDB_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pdb_pkg.sv =====
// Shared types and constants of the Porter-Duff pixel blender.
`default_nettype none

package pdb_pkg;

    localparam int NCH       = 4;
    localparam int PIPE_DEPTH = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] CH_MAX  = 8'd255;
    localparam logic [7:0] CH_HALF = 8'd127;

    localparam logic [3:0] MODE_CLEAR    = 4'd0;
    localparam logic [3:0] MODE_SRC      = 4'd1;
    localparam logic [3:0] MODE_DST      = 4'd2;
    localparam logic [3:0] MODE_SRC_OVER = 4'd3;
    localparam logic [3:0] MODE_DST_OVER = 4'd4;
    localparam logic [3:0] MODE_SRC_IN   = 4'd5;
    localparam logic [3:0] MODE_DST_IN   = 4'd6;
    localparam logic [3:0] MODE_SRC_OUT  = 4'd7;
    localparam logic [3:0] MODE_DST_OUT  = 4'd8;
    localparam logic [3:0] MODE_SRC_ATOP = 4'd9;
    localparam logic [3:0] MODE_DST_ATOP = 4'd10;
    localparam logic [3:0] MODE_XOR      = 4'd11;

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_PIXEL  = 2'd1;

    // per-channel operands: base + mulb(x1,y1) + mulb(x2,y2), or base - mulb(x1,y1) when neg
    typedef struct packed {
        logic [8:0] base;
        logic       neg;
        logic [8:0] x1;
        logic [7:0] y1;
        logic [7:0] x2;
        logic [7:0] y2;
    } chan_ops_t;

    typedef struct packed {
        logic [8:0] base;
        logic       neg;
    } side_t;

endpackage

`default_nettype wire

// ===== src/pdb_operand_sel.sv =====
// Stage 1: mode decode and operand selection for all four channels.
`default_nettype none

module pdb_operand_sel
    import pdb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [31:0]           dest_pixel,
    input  wire logic [31:0]           src_pixel,
    input  wire logic [3:0]            blend_mode,
    output logic                       out_valid,
    output chan_ops_t [NCH-1:0]        ops
);

    chan_ops_t [NCH-1:0] ops_reg;
    chan_ops_t [NCH-1:0] ops_next;
    logic                valid_reg;

    always_comb
    begin
        logic [7:0] sa;
        logic [7:0] da;
        logic [7:0] sc;
        logic [7:0] dc;
        logic [7:0] inv_sa;
        logic [7:0] inv_da;
        logic       is_alpha;
        sa     = src_pixel[31:24];
        da     = dest_pixel[31:24];
        inv_sa = CH_MAX - sa;
        inv_da = CH_MAX - da;
        for (int k = 0; k < NCH; k++)
        begin
            sc       = src_pixel[31 - 8*k -: 8];
            dc       = dest_pixel[31 - 8*k -: 8];
            is_alpha = (k == 0);
            ops_next[k] = '0;
            case (blend_mode)
                MODE_CLEAR:
                begin
                    ops_next[k].base = 9'd0;
                end
                MODE_SRC:
                begin
                    ops_next[k].base = {1'b0, sc};
                end
                MODE_SRC_OVER:
                begin
                    ops_next[k].base = {1'b0, sc};
                    ops_next[k].x1   = {1'b0, inv_sa};
                    ops_next[k].y1   = dc;
                end
                MODE_DST_OVER:
                begin
                    ops_next[k].base = {1'b0, dc};
                    ops_next[k].x1   = {1'b0, inv_da};
                    ops_next[k].y1   = sc;
                end
                MODE_SRC_IN:
                begin
                    ops_next[k].x1 = {1'b0, sc};
                    ops_next[k].y1 = da;
                end
                MODE_DST_IN:
                begin
                    ops_next[k].x1 = {1'b0, sa};
                    ops_next[k].y1 = dc;
                end
                MODE_SRC_OUT:
                begin
                    ops_next[k].x1 = {1'b0, sc};
                    ops_next[k].y1 = inv_da;
                end
                MODE_DST_OUT:
                begin
                    ops_next[k].x1 = {1'b0, dc};
                    ops_next[k].y1 = inv_sa;
                end
                MODE_SRC_ATOP:
                begin
                    if (is_alpha)
                    begin
                        ops_next[k].base = {1'b0, da};
                    end
                    else
                    begin
                        ops_next[k].x1 = {1'b0, sc};
                        ops_next[k].y1 = da;
                        ops_next[k].x2 = dc;
                        ops_next[k].y2 = inv_sa;
                    end
                end
                MODE_DST_ATOP:
                begin
                    if (is_alpha)
                    begin
                        ops_next[k].base = {1'b0, sa};
                    end
                    else
                    begin
                        ops_next[k].x1 = {1'b0, dc};
                        ops_next[k].y1 = sa;
                        ops_next[k].x2 = sc;
                        ops_next[k].y2 = inv_da;
                    end
                end
                MODE_XOR:
                begin
                    if (is_alpha)
                    begin
                        // Sa + Da - mulb(2*Sa, Da)
                        ops_next[k].base = {1'b0, sa} + {1'b0, da};
                        ops_next[k].neg  = 1'b1;
                        ops_next[k].x1   = {sa, 1'b0};
                        ops_next[k].y1   = da;
                    end
                    else
                    begin
                        ops_next[k].x1 = {1'b0, sc};
                        ops_next[k].y1 = inv_da;
                        ops_next[k].x2 = dc;
                        ops_next[k].y2 = inv_sa;
                    end
                end
                default:
                begin
                    // dst and unused codes pass the destination through
                    ops_next[k].base = {1'b0, dc};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ops_reg <= ops_next;
    end

    assign out_valid = valid_reg;
    assign ops       = ops_reg;

endmodule

`default_nettype wire

// ===== src/pdb_mulb.sv =====
// Stages 2 to 4: byte product rounded as (x*y+127)/255.
`default_nettype none

module pdb_mulb
    import pdb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic [8:0] x,
    input  wire logic [7:0] y,
    output logic [8:0]      q
);

    logic [16:0] prod_reg;
    logic [16:0] prod_next;
    logic [8:0]  est_reg;
    logic [8:0]  est_next;
    logic [9:0]  rem_reg;
    logic [9:0]  rem_next;
    logic [8:0]  q_reg;
    logic [8:0]  q_next;
    logic [16:0] acc;
    logic [16:0] est_x255;

    assign prod_next = 17'(x * y) + 17'(CH_HALF);

    // reciprocal estimate, at most two short of the quotient
    assign acc      = prod_reg + {8'd0, prod_reg[16:8]};
    assign est_next = acc[16:8];
    assign est_x255 = {est_next, 8'd0} - {8'd0, est_next};
    assign rem_next = 10'(prod_reg - est_x255);

    always_comb
    begin
        if (rem_reg >= 10'd510)
        begin
            q_next = est_reg + 9'd2;
        end
        else if (rem_reg >= 10'd255)
        begin
            q_next = est_reg + 9'd1;
        end
        else
        begin
            q_next = est_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        est_reg  <= est_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// ===== src/pdb_chan_sum.sv =====
// Stage 5: channel sums, saturation and pixel assembly.
`default_nettype none

module pdb_chan_sum
    import pdb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire side_t [NCH-1:0]      side,
    input  wire logic [NCH-1:0][8:0]  q1,
    input  wire logic [NCH-1:0][8:0]  q2,
    output logic                      out_valid,
    output logic [31:0]               pixel
);

    logic        valid_reg;
    logic [31:0] pixel_reg;
    logic [31:0] pixel_next;

    always_comb
    begin
        logic signed [10:0] v;
        pixel_next = '0;
        for (int k = 0; k < NCH; k++)
        begin
            if (side[k].neg)
            begin
                v = $signed({2'b00, side[k].base}) - $signed({2'b00, q1[k]});
            end
            else
            begin
                v = $signed({2'b00, side[k].base}) + $signed({2'b00, q1[k]})
                    + $signed({2'b00, q2[k]});
            end
            if (v < 0)
            begin
                pixel_next[31 - 8*k -: 8] = 8'd0;
            end
            else if (v > $signed({3'b000, CH_MAX}))
            begin
                pixel_next[31 - 8*k -: 8] = CH_MAX;
            end
            else
            begin
                pixel_next[31 - 8*k -: 8] = v[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign out_valid = valid_reg;
    assign pixel     = pixel_reg;

endmodule

`default_nettype wire

// ===== src/porter_duff_pixel_blend.sv =====
// Top level of the Porter-Duff pixel blender: config registers and pipeline.
//
//  channel   | signals                                   | transfer
//  ----------+-------------------------------------------+-------------------------
//  input     | start, busy, dest_pixel                   | start & !busy
//  result    | result_valid, result_pixel                | result_valid, one cycle
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// One pixel per clock; busy is never raised. The pipeline stages are operand
// select, multiply, reciprocal estimate, quotient correction, sum and saturate.
// The multiply-by-255 divide path sets the stage split.
// Asynchronous active-low reset clears valid bits; blend_mode resets to
// src_over, src_pixel to zero. The receiver cannot stall, so nothing holds.
`default_nettype none

module porter_duff_pixel_blend
    import pdb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [31:0]          dest_pixel,
    output logic                      result_valid,
    output logic [31:0]               result_pixel,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    logic [3:0]  blend_mode_reg;
    logic [31:0] src_pixel_reg;

    logic                s1_valid;
    chan_ops_t [NCH-1:0] s1_ops;
    side_t [NCH-1:0]     s1_side;

    logic            s2_valid_reg;
    logic            s3_valid_reg;
    logic            s4_valid_reg;
    side_t [NCH-1:0] side_s2_reg;
    side_t [NCH-1:0] side_s3_reg;
    side_t [NCH-1:0] side_s4_reg;

    logic [NCH-1:0][8:0] q1;
    logic [NCH-1:0][8:0] q2;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg <= MODE_SRC_OVER;
            src_pixel_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BLEND_MODE: blend_mode_reg <= cfg_data[3:0];
                REG_SRC_PIXEL:  src_pixel_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    pdb_operand_sel u_operand_sel (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .dest_pixel (dest_pixel),
        .src_pixel  (src_pixel_reg),
        .blend_mode (blend_mode_reg),
        .out_valid  (s1_valid),
        .ops        (s1_ops)
    );

    for (genvar k = 0; k < NCH; k++)
    begin : g_chan
        assign s1_side[k].base = s1_ops[k].base;
        assign s1_side[k].neg  = s1_ops[k].neg;

        pdb_mulb u_mulb1 (
            .clk (clk),
            .x   (s1_ops[k].x1),
            .y   (s1_ops[k].y1),
            .q   (q1[k])
        );

        pdb_mulb u_mulb2 (
            .clk (clk),
            .x   ({1'b0, s1_ops[k].x2}),
            .y   (s1_ops[k].y2),
            .q   (q2[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side_s2_reg <= s1_side;
        side_s3_reg <= side_s2_reg;
        side_s4_reg <= side_s3_reg;
    end

    pdb_chan_sum u_chan_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .side      (side_s4_reg),
        .q1        (q1),
        .q2        (q2),
        .out_valid (result_valid),
        .pixel     (result_pixel)
    );

endmodule

`default_nettype wire

// ===== src/pdb_checker.sv =====
// Port-level checker for the Porter-Duff pixel blender, bound to the top level.
`default_nettype none

`include "porter_duff_pixel_blend_defines.svh"

module pdb_checker
    import pdb_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic result_valid,
    input wire logic cfg_valid,
    input wire logic cfg_ready
);

    logic in_xfer;

    assign in_xfer = start && !busy;

    `PDB_ASSERT_IMP(a_result_follows, clk, rst_n, in_xfer, ##PIPE_DEPTH result_valid, "pixel lost in pipeline")
    `PDB_ASSERT_IMP(a_no_spurious, clk, rst_n, result_valid, $past(in_xfer, PIPE_DEPTH), "result without transfer")
    `PDB_ASSERT_NXT(a_idle_quiet, clk, rst_n, !in_xfer, ##(PIPE_DEPTH-1) !result_valid, "result without transfer")
    `PDB_ASSERT_IMP(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "config write refused")

endmodule

bind porter_duff_pixel_blend pdb_checker u_pdb_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for porter_duff_pixel_blend: random pixel traffic across all blend modes.
`default_nettype none

module tb
    import pdb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL = CH_MAX;
    localparam int HALF = CH_HALF;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [31:0]          dest_pixel = '0;
    logic                 result_valid;
    logic [31:0]          result_pixel;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_BLEND_MODE;
    logic [31:0]          cfg_data = '0;

    logic [3:0]  mode_reg = MODE_SRC_OVER;
    logic [31:0] src_reg = '0;

    logic [31:0] dest_backlog[$];
    logic [31:0] expected_pixels[$];
    int          pixels_queued = 0;
    int          pixels_taken = 0;
    int          mismatches = 0;
    bit          in_xfer = 1'b0;
    bit          calm = 1'b0;

    porter_duff_pixel_blend u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .dest_pixel   (dest_pixel),
        .result_valid (result_valid),
        .result_pixel (result_pixel),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int scale8(int a, int b);
        return (a * b + HALF) / FULL;
    endfunction

    function automatic logic [31:0] blend_pixel(logic [3:0] mode, logic [31:0] src,
                                                logic [31:0] dst);
        int sa, da, sc, dc, v, k;
        logic [31:0] res;
        sa = src[31:24];
        da = dst[31:24];
        res = '0;
        for (k = 0; k < NCH; k++)
        begin
            sc = (src >> (24 - 8 * k)) & FULL;
            dc = (dst >> (24 - 8 * k)) & FULL;
            case (mode)
                MODE_CLEAR:    v = 0;
                MODE_SRC:      v = sc;
                MODE_DST:      v = dc;
                MODE_SRC_OVER: v = sc + scale8(FULL - sa, dc);
                MODE_DST_OVER: v = dc + scale8(FULL - da, sc);
                MODE_SRC_IN:   v = scale8(sc, da);
                MODE_DST_IN:   v = scale8(sa, dc);
                MODE_SRC_OUT:  v = scale8(sc, FULL - da);
                MODE_DST_OUT:  v = scale8(dc, FULL - sa);
                MODE_SRC_ATOP: v = (k == 0) ? da : scale8(sc, da) + scale8(dc, FULL - sa);
                MODE_DST_ATOP: v = (k == 0) ? sa : scale8(dc, sa) + scale8(sc, FULL - da);
                MODE_XOR:      v = (k == 0) ? sa + da - scale8(2 * sa, da)
                                            : scale8(sc, FULL - da) + scale8(dc, FULL - sa);
                default:       v = dc;
            endcase
            if (v < 0)
                v = 0;
            else if (v > FULL)
                v = FULL;
            res[31 - 8 * k -: 8] = v[7:0];
        end
        return res;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
    endtask

    // driver: holds start until the transfer, then picks the next pixel or a gap
    always @(negedge clk)
    begin
        if (rst_n && (!start || in_xfer))
        begin
            if (dest_backlog.size() > 0 && (calm || $urandom_range(99) >= 14))
            begin
                start      <= 1'b1;
                dest_pixel <= dest_backlog.pop_front();
            end
            else
            begin
                start      <= 1'b0;
                dest_pixel <= $urandom;
            end
        end
    end

    // monitor: check results first, then record the pixel taken at this edge
    always @(posedge clk)
    begin
        in_xfer = 1'b0;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_pixels.size() == 0)
                    note_mismatch("unexpected result", 'x, result_pixel);
                else if (result_pixel !== expected_pixels[0])
                    note_mismatch("result_pixel", expected_pixels.pop_front(), result_pixel);
                else
                    void'(expected_pixels.pop_front());
            end
            if (start && !busy)
            begin
                expected_pixels = {expected_pixels, blend_pixel(mode_reg, src_reg, dest_pixel)};
                pixels_taken++;
                in_xfer = 1'b1;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_BLEND_MODE)
            mode_reg = data[3:0];
        else if (idx == REG_SRC_PIXEL)
            src_reg = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_pixel(logic [31:0] p);
        dest_backlog = {dest_backlog, p};
        pixels_queued++;
    endtask

    task automatic wait_idle();
        do @(negedge clk); while (pixels_taken != pixels_queued || expected_pixels.size() != 0);
    endtask

    function automatic logic [31:0] rand_pixel();
        int pick, a;
        logic [31:0] p;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            case ($urandom_range(3))
                0:       p = 32'h0000_0000;
                1:       p = 32'hFFFF_FFFF;
                2:       p = 32'hFF00_0000;
                default: p = 32'h00FF_FFFF;
            endcase
        end
        else if (pick < 70)
        begin
            // validly premultiplied: every colour channel at most alpha
            case ($urandom_range(9))
                0:       a = 0;
                1:       a = FULL;
                default: a = $urandom_range(FULL);
            endcase
            p[31:24] = a[7:0];
            p[23:16] = 8'($urandom_range(a));
            p[15:8]  = 8'($urandom_range(a));
            p[7:0]   = 8'($urandom_range(a));
        end
        else
            p = $urandom;
        return p;
    endfunction

    initial
    begin
        int m, n, i, phase, sent;
        logic [31:0] word;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values of both registers
        queue_pixel(32'h0000_0000);
        queue_pixel(32'hFFFF_FFFF);
        queue_pixel(32'h8040_2010);
        wait_idle();

        // every mode code, unused ones too, with saturating operands
        write_reg(REG_SRC_PIXEL, 32'hC0FF_FF10);
        for (m = 0; m < 16; m++)
        begin
            write_reg(REG_BLEND_MODE, 32'(m));
            queue_pixel(32'h40FF_C080);
            wait_idle();
        end

        sent = 0;
        phase = 0;
        while (sent < 1900)
        begin
            if ($urandom_range(3) != 0 || phase == 0)
            begin
                m = ($urandom_range(99) < 15) ? $urandom_range(15, 12) : $urandom_range(11);
                word = ($urandom_range(3) == 0) ? (($urandom & ~32'hF) | 32'(m)) : 32'(m);
                write_reg(REG_BLEND_MODE, word);
            end
            if ($urandom_range(3) != 0 || phase == 0)
            begin
                case ($urandom_range(9))
                    0:       word = 32'h0000_0000;
                    1:       word = 32'hFFFF_FFFF;
                    default: word = rand_pixel();
                endcase
                write_reg(REG_SRC_PIXEL, word);
            end
            calm = (phase == 5);
            n = calm ? 300 : $urandom_range(90, 10);
            for (i = 0; i < n; i++)
                queue_pixel(rand_pixel());
            sent += n;
            wait_idle();
            calm = 1'b0;
            phase++;
        end

        wait_idle();
        repeat (PIPE_DEPTH * 4) @(negedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== porter_duff_pixel_blend.f =====
+incdir+src
src/pdb_pkg.sv
src/pdb_operand_sel.sv
src/pdb_mulb.sv
src/pdb_chan_sum.sv
src/porter_duff_pixel_blend.sv
src/pdb_checker.sv
sim/tb.sv
